/* rtl/assert_macros.svh */
// Assertion shorthands for the block's checkers.
// Each samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/igcc_pkg.sv */
package igcc_pkg;

    // Field and register widths
    localparam int POS_W      = 32;
    localparam int SIZE_W     = 31;
    localparam int GRID_W     = 9;
    localparam int INFL_W     = 5;
    localparam int CELL_W     = 8;
    localparam int ADDR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default sizing
    localparam int MAX_DIM_DEF       = 256;
    localparam int MAX_INFLATION_DEF = 31;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATION   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd7;

    // Reset values
    localparam logic [SIZE_W-1:0]        CELL_SIZE_RST   = 31'd3277;
    localparam logic [GRID_W-1:0]        GRID_DIM_RST    = 9'd256;
    localparam logic [INFL_W-1:0]        INFLATION_RST   = 5'd10;
    localparam logic signed [CELL_W-1:0] THRESHOLD_RST   = 8'sd50;

endpackage

/* rtl/inflated_grid_collision_check_core.sv */
// Occupancy-grid collision check with an inflated footprint. Items enter on
// start while busy is low; cmd selects a cell write or a query. Every item
// yields exactly one result, shown on collision and center_outside for the
// single cycle in which done is high; the receiver cannot stall it, so sample
// it then. A cell write's result appears in the next cycle; so does a query's
// result while map_present is 0. A query with a map runs bit-serial division
// (both axes together), then setup steps that check the centre, clip the
// window and form the row base, then reads each window cell that lies on the
// grid in turn, then drains the last read. The window holds at most
// (2r+1)^2 cells for inflation r (default 10). A query whose centre lies off
// the grid ends right after the division; a scan ends at the first cell
// above the threshold. The window scan is paced by the single read port of
// the cell store. The store has no reset and needs no clearing pass: only
// cells that software has written may be read. Configuration registers may
// be written at any edge but must only change while busy is low and no
// result is pending.
module inflated_grid_collision_check_core
    import igcc_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int MAX_INFLATION = MAX_INFLATION_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // Configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,

    // Item input
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic signed [POS_W-1:0]      pos_x,
    input  logic signed [POS_W-1:0]      pos_y,
    input  logic [ADDR_W-1:0]            cell_index,
    input  logic signed [CELL_W-1:0]     cell_value,

    // Result output
    output logic                         done,
    output logic                         collision,
    output logic                         center_outside
);

    // Width of a cell coordinate or a grid dimension (holds MAX_DIM itself)
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    // Width of the clamped inflation radius
    localparam int INF_W   = (MAX_INFLATION < 2) ? 1 : $clog2(MAX_INFLATION + 1);
    // Width of a centre coordinate plus the radius
    localparam int SUM_W   = $clog2(MAX_DIM + MAX_INFLATION + 1);
    localparam int PROD_W  = 2 * DIM_W;
    localparam int CNT_W   = $clog2(POS_W);
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(POS_W - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_CENTRE = 7'b0000100,
        S_BOUND  = 7'b0001000,
        S_BASE   = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DRAIN  = 7'b1000000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                        map_present_reg;
    logic signed [POS_W-1:0]     origin_x_reg;
    logic signed [POS_W-1:0]     origin_y_reg;
    logic [SIZE_W-1:0]           cell_size_reg;
    logic [GRID_W-1:0]           grid_width_reg;
    logic [GRID_W-1:0]           grid_height_reg;
    logic [INFL_W-1:0]           inflation_reg;
    logic signed [CELL_W-1:0]    threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_present_reg <= 1'b0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_size_reg   <= CELL_SIZE_RST;
            grid_width_reg  <= GRID_DIM_RST;
            grid_height_reg <= GRID_DIM_RST;
            inflation_reg   <= INFLATION_RST;
            threshold_reg   <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAP_PRESENT: map_present_reg <= cfg_wdata[0];
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                CFG_CELL_SIZE:   cell_size_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[GRID_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[GRID_W-1:0];
                CFG_INFLATION:   inflation_reg   <= cfg_wdata[INFL_W-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_wdata[CELL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp grid size and radius to what the datapath was built for.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [INF_W-1:0] r_eff;

    assign w_eff = (grid_width_reg > MAX_DIM)  ? DIM_W'(MAX_DIM) : DIM_W'(grid_width_reg);
    assign h_eff = (grid_height_reg > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(grid_height_reg);
    assign r_eff = (inflation_reg > MAX_INFLATION) ? INF_W'(MAX_INFLATION)
                                                   : INF_W'(inflation_reg);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic                     done_reg, done_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]         div_cnt_reg, div_cnt_next;
    logic                     collision_reg, collision_next;
    logic                     outside_reg, outside_next;

    // Divider: remainder and dividend/quotient shift register for each axis
    logic [SIZE_W-1:0]        divisor_reg, divisor_next;
    logic [SIZE_W-1:0]        rem_x_reg, rem_x_next;
    logic [SIZE_W-1:0]        rem_y_reg, rem_y_next;
    logic [POS_W-1:0]         quo_x_reg, quo_x_next;
    logic [POS_W-1:0]         quo_y_reg, quo_y_next;
    logic                     neg_x_reg, neg_x_next;
    logic                     neg_y_reg, neg_y_next;

    // Centre and window
    logic [DIM_W-1:0]         mx_reg, mx_next;
    logic [DIM_W-1:0]         my_reg, my_next;
    logic [DIM_W-1:0]         x_lo_reg, x_lo_next;
    logic [DIM_W-1:0]         x_hi_reg, x_hi_next;
    logic [DIM_W-1:0]         y_lo_reg, y_lo_next;
    logic [DIM_W-1:0]         y_hi_reg, y_hi_next;
    logic [DIM_W-1:0]         cx_reg, cx_next;
    logic [DIM_W-1:0]         cy_reg, cy_next;
    logic [ADDR_W-1:0]        row_base_reg, row_base_next;

    // ------------------------------------------------------------------
    // Cell store: one write port for items, one registered read port
    // ------------------------------------------------------------------
    logic signed [CELL_W-1:0] grid_cells [STORE_DEPTH];
    logic signed [CELL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     accept;
    logic                     mem_we;

    assign accept  = start && (state_reg == S_IDLE);
    assign mem_we  = accept && (cmd == CMD_WRITE);
    assign rd_addr = row_base_reg + ADDR_W'(cx_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_cells[cell_index] <= cell_value;
        end
        rd_data_reg <= grid_cells[rd_addr];
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [POS_W:0]           diff_x, diff_y;
    logic [POS_W-1:0]         mag_x, mag_y;
    logic [SIZE_W:0]          trial_x, trial_y;
    logic                     ge_x, ge_y;
    logic                     out_x, out_y;
    logic [SUM_W-1:0]         x_sum, y_sum;
    logic [PROD_W-1:0]        base_prod;
    logic                     hit;
    logic                     row_last, col_last;

    // Offset from the origin and its magnitude; the sign is applied later.
    assign diff_x = {pos_x[POS_W-1], pos_x} - {origin_x_reg[POS_W-1], origin_x_reg};
    assign diff_y = {pos_y[POS_W-1], pos_y} - {origin_y_reg[POS_W-1], origin_y_reg};
    assign mag_x  = diff_x[POS_W] ? POS_W'(-diff_x) : diff_x[POS_W-1:0];
    assign mag_y  = diff_y[POS_W] ? POS_W'(-diff_y) : diff_y[POS_W-1:0];

    // One restoring step per cycle: bring in the next dividend bit.
    assign trial_x = {rem_x_reg, quo_x_reg[POS_W-1]};
    assign trial_y = {rem_y_reg, quo_y_reg[POS_W-1]};
    assign ge_x    = trial_x >= {1'b0, divisor_reg};
    assign ge_y    = trial_y >= {1'b0, divisor_reg};

    // Truncation toward zero: a negative offset under one cell lands in cell 0.
    assign out_x = (neg_x_reg && (quo_x_reg != '0)) || (quo_x_reg >= POS_W'(w_eff));
    assign out_y = (neg_y_reg && (quo_y_reg != '0)) || (quo_y_reg >= POS_W'(h_eff));

    assign x_sum     = SUM_W'(mx_reg) + SUM_W'(r_eff);
    assign y_sum     = SUM_W'(my_reg) + SUM_W'(r_eff);
    assign base_prod = PROD_W'(y_lo_reg) * PROD_W'(w_eff);

    assign hit      = rd_valid_reg && (rd_data_reg > threshold_reg);
    assign col_last = (cx_reg == x_hi_reg);
    assign row_last = (cy_reg == y_hi_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        rd_valid_next  = 1'b0;
        div_cnt_next   = div_cnt_reg;
        collision_next = collision_reg;
        outside_next   = outside_reg;
        divisor_next   = divisor_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        quo_x_next     = quo_x_reg;
        quo_y_next     = quo_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        x_lo_next      = x_lo_reg;
        x_hi_next      = x_hi_reg;
        y_lo_next      = y_lo_reg;
        y_hi_next      = y_hi_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        row_base_next  = row_base_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd == CMD_QUERY) && map_present_reg)
                    begin
                        // Load both dividers; a zero cell size counts as one unit.
                        divisor_next = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;
                        rem_x_next   = '0;
                        rem_y_next   = '0;
                        quo_x_next   = mag_x;
                        quo_y_next   = mag_y;
                        neg_x_next   = diff_x[POS_W];
                        neg_y_next   = diff_y[POS_W];
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        // Cell write, or a query with no map: safe at once.
                        done_next      = 1'b1;
                        collision_next = 1'b0;
                        outside_next   = 1'b0;
                    end
                end
            end

            S_DIV:
            begin
                rem_x_next   = ge_x ? SIZE_W'(trial_x - {1'b0, divisor_reg})
                                    : trial_x[SIZE_W-1:0];
                rem_y_next   = ge_y ? SIZE_W'(trial_y - {1'b0, divisor_reg})
                                    : trial_y[SIZE_W-1:0];
                quo_x_next   = {quo_x_reg[POS_W-2:0], ge_x};
                quo_y_next   = {quo_y_reg[POS_W-2:0], ge_y};
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_CENTRE;
                end
            end

            S_CENTRE:
            begin
                if (out_x || out_y)
                begin
                    done_next      = 1'b1;
                    collision_next = 1'b1;
                    outside_next   = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mx_next    = DIM_W'(quo_x_reg);
                    my_next    = DIM_W'(quo_y_reg);
                    state_next = S_BOUND;
                end
            end

            S_BOUND:
            begin
                // Clip the window to the grid so the scan never leaves it.
                x_lo_next  = (SUM_W'(mx_reg) >= SUM_W'(r_eff))
                           ? DIM_W'(SUM_W'(mx_reg) - SUM_W'(r_eff)) : '0;
                y_lo_next  = (SUM_W'(my_reg) >= SUM_W'(r_eff))
                           ? DIM_W'(SUM_W'(my_reg) - SUM_W'(r_eff)) : '0;
                x_hi_next  = (x_sum >= SUM_W'(w_eff)) ? (w_eff - DIM_W'(1)) : DIM_W'(x_sum);
                y_hi_next  = (y_sum >= SUM_W'(h_eff)) ? (h_eff - DIM_W'(1)) : DIM_W'(y_sum);
                state_next = S_BASE;
            end

            S_BASE:
            begin
                row_base_next = ADDR_W'(base_prod);
                cx_next       = x_lo_reg;
                cy_next       = y_lo_reg;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    // Obstacle found: drop the reads still in flight.
                    done_next      = 1'b1;
                    collision_next = 1'b1;
                    outside_next   = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rd_valid_next = 1'b1;
                    if (col_last)
                    begin
                        cx_next       = x_lo_reg;
                        cy_next       = cy_reg + DIM_W'(1);
                        row_base_next = row_base_reg + ADDR_W'(w_eff);
                        if (row_last)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else
                    begin
                        cx_next = cx_reg + DIM_W'(1);
                    end
                end
            end

            S_DRAIN:
            begin
                done_next      = 1'b1;
                collision_next = hit;
                outside_next   = 1'b0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            rd_valid_reg <= rd_valid_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    // Payload and datapath state
    always_ff @(posedge clk)
    begin
        collision_reg <= collision_next;
        outside_reg   <= outside_next;
        divisor_reg   <= divisor_next;
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        quo_x_reg     <= quo_x_next;
        quo_y_reg     <= quo_y_next;
        neg_x_reg     <= neg_x_next;
        neg_y_reg     <= neg_y_next;
        mx_reg        <= mx_next;
        my_reg        <= my_next;
        x_lo_reg      <= x_lo_next;
        x_hi_reg      <= x_hi_next;
        y_lo_reg      <= y_lo_next;
        y_hi_reg      <= y_hi_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        row_base_reg  <= row_base_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign collision      = collision_reg;
    assign center_outside = outside_reg;

endmodule

/* rtl/igcc_checker.sv */
`include "assert_macros.svh"

module igcc_checker
    import igcc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic done,
    input logic collision,
    input logic center_outside
);

    // A result is shown only once the block has returned to idle.
    `ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

    // An off-grid centre is always a collision.
    `ASSERT_SAME(a_outside_coll, done && center_outside, collision, "outside without collision")

    // A cell write answers in the next cycle with a safe result.
    `ASSERT_NEXT(a_write_result, start && !busy && (cmd == CMD_WRITE), done && !collision && !center_outside, "write item result wrong")

    // An accepted query either answers at once or holds busy.
    `ASSERT_NEXT(a_query_moves, start && !busy && (cmd == CMD_QUERY), busy || done, "query item lost")

endmodule

bind inflated_grid_collision_check_core igcc_checker u_igcc_checker (.*);

/* verif/testbench.sv */
module testbench;
    import igcc_pkg::*;

    // Run sizing: item budget (grid fills included), generous cycle limit, settle pads.
    localparam int ITEM_TARGET  = 700;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int IDLE_PAD     = 4;
    // Longest query: division, setup and a full 63 by 63 window scan.
    localparam int END_PAD      = 4100;

    // One input item as it crosses the start handshake.
    typedef struct {
        logic                     cmd;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic [ADDR_W-1:0]        idx;
        logic signed [CELL_W-1:0] val;
    } grid_item_t;

    // One result item.
    typedef struct {
        logic collision;
        logic outside;
    } verdict_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       start = 1'b0;
    logic                       cmd = CMD_WRITE;
    logic signed [POS_W-1:0]    pos_x = '0;
    logic signed [POS_W-1:0]    pos_y = '0;
    logic [ADDR_W-1:0]          cell_index = '0;
    logic signed [CELL_W-1:0]   cell_value = '0;
    logic                       busy;
    logic                       done;
    logic                       collision;
    logic                       center_outside;

    // Shadow copy of the configuration registers, updated as each write lands.
    logic                       map_on = 1'b0;
    logic signed [POS_W-1:0]    org_x = '0;
    logic signed [POS_W-1:0]    org_y = '0;
    logic [SIZE_W-1:0]          cell_len = CELL_SIZE_RST;
    logic [GRID_W-1:0]          cols = GRID_DIM_RST;
    logic [GRID_W-1:0]          rows = GRID_DIM_RST;
    logic [INFL_W-1:0]          infl = INFLATION_RST;
    logic signed [CELL_W-1:0]   thresh = THRESHOLD_RST;

    // Shadow copy of the occupancy store.
    logic signed [CELL_W-1:0]   cells [0:(1 << ADDR_W) - 1];

    grid_item_t                 pending_items[$];
    verdict_t                   expected_verdicts[$];
    logic                       took = 1'b0;
    int                         idle_cnt = 0;
    bit                         steady_feed = 1'b0;
    int                         mismatches = 0;
    int                         cycle_count = 0;
    int                         queued_items = 0;
    int                         filled_cnt = 0;
    int                         density = 0;

    inflated_grid_collision_check_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .cell_index     (cell_index),
        .cell_value     (cell_value),
        .done           (done),
        .collision      (collision),
        .center_outside (center_outside)
    );

    always #6 clk = ~clk;

    // Grid dimension as the block uses it: anything above MAX_DIM is clamped.
    function automatic longint clamp_dim(logic [GRID_W-1:0] d);
        return (d > MAX_DIM_DEF) ? longint'(MAX_DIM_DEF) : longint'(d);
    endfunction

    // Work out the result of one item and apply a cell write to the shadow store.
    // The window scan stops at the first cell strictly above the threshold.
    function automatic verdict_t predict_verdict(grid_item_t it);
        verdict_t v;
        longint   w, h, r, pitch, mx, my, cx, cy, dx, dy;
        v.collision = 1'b0;
        v.outside   = 1'b0;
        if (it.cmd == CMD_WRITE)
        begin
            cells[it.idx] = it.val;
        end
        else if (map_on)
        begin
            w     = clamp_dim(cols);
            h     = clamp_dim(rows);
            r     = (infl > MAX_INFLATION_DEF) ? longint'(MAX_INFLATION_DEF) : longint'(infl);
            pitch = (cell_len == 0) ? 64'sd1 : longint'(cell_len);
            // Signed division truncates toward zero, as the block does.
            mx = (longint'(it.px) - longint'(org_x)) / pitch;
            my = (longint'(it.py) - longint'(org_y)) / pitch;
            if (mx < 0 || my < 0 || mx >= w || my >= h)
            begin
                v.collision = 1'b1;
                v.outside   = 1'b1;
            end
            else
            begin
                for (dx = -r; dx <= r && !v.collision; dx++)
                begin
                    for (dy = -r; dy <= r && !v.collision; dy++)
                    begin
                        cx = mx + dx;
                        cy = my + dy;
                        if (cx >= 0 && cx < w && cy >= 0 && cy < h)
                        begin
                            if (cells[cy * w + cx] > thresh)
                                v.collision = 1'b1;
                        end
                    end
                end
            end
        end
        return v;
    endfunction

    // Gap before the next item: mostly none or short, now and then long.
    function automatic int draw_gap();
        int p;
        p = $urandom_range(99);
        if (steady_feed || p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(3, 1);
        if (p < 97)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // Cell value either strictly above the threshold (an obstacle) or at or below it.
    function automatic logic signed [CELL_W-1:0] draw_cell(bit blocked);
        int lo, hi;
        lo = -128;
        hi = int'(thresh);
        if (blocked && thresh != 8'sd127)
        begin
            lo = int'(thresh) + 1;
            hi = 127;
        end
        return 8'(lo + int'($urandom_range(hi - lo)));
    endfunction

    // Keep the low w bits of a register value; sometimes dirty the unused upper bits.
    function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] v, int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = 32'((64'd1 << w) - 1);
        if ($urandom_range(3) != 0)
            return v & keep;
        return (v & keep) | ($urandom & ~keep);
    endfunction

    // Write one register at an edge and mirror it into the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_MAP_PRESENT: map_on   = data[0];
            CFG_ORIGIN_X:    org_x    = data;
            CFG_ORIGIN_Y:    org_y    = data;
            CFG_CELL_SIZE:   cell_len = data[SIZE_W-1:0];
            CFG_GRID_WIDTH:  cols     = data[GRID_W-1:0];
            CFG_GRID_HEIGHT: rows     = data[GRID_W-1:0];
            CFG_INFLATION:   infl     = data[INFL_W-1:0];
            CFG_THRESHOLD:   thresh   = data[CELL_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_write(logic [ADDR_W-1:0] idx, logic signed [CELL_W-1:0] val);
        grid_item_t it;
        it.cmd = CMD_WRITE;
        it.px  = $urandom;
        it.py  = $urandom;
        it.idx = idx;
        it.val = val;
        pending_items.insert(pending_items.size(), it);
        queued_items++;
    endtask

    task automatic queue_query(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
        grid_item_t it;
        it.cmd = CMD_QUERY;
        it.px  = x;
        it.py  = y;
        it.idx = 16'($urandom);
        it.val = 8'($urandom);
        pending_items.insert(pending_items.size(), it);
        queued_items++;
    endtask

    // Write every cell that a query can read at or above the fill mark, so no
    // unwritten cell is ever scanned; cells below the mark keep their values.
    task automatic fill_region(int permille);
        int n, i;
        n = int'(clamp_dim(cols) * clamp_dim(rows));
        for (i = filled_cnt; i < n; i++)
            queue_write(16'(i), draw_cell($urandom_range(999) < permille));
        if (n > filled_cnt)
            filled_cnt = n;
    endtask

    // Query aimed at a cell on or just around the grid, at a random spot inside it.
    task automatic queue_aimed_query();
        longint pitch, tx, ty, px, py;
        pitch = (cell_len == 0) ? 64'sd1 : longint'(cell_len);
        tx = longint'($urandom_range(int'(clamp_dim(cols)) + 3)) - 2;
        ty = longint'($urandom_range(int'(clamp_dim(rows)) + 3)) - 2;
        px = longint'(org_x) + tx * pitch + longint'($urandom_range(32'(pitch - 1)));
        py = longint'(org_y) + ty * pitch + longint'($urandom_range(32'(pitch - 1)));
        queue_query(px[POS_W-1:0], py[POS_W-1:0]);
    endtask

    // Block until every item has gone in and every result has come out.
    task automatic wait_idle();
        while (pending_items.size() != 0 || start || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    // Pick a fresh setting for every register, extremes included.
    task automatic choose_settings();
        int w, h;
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(5))
            0, 1, 2:
            begin
                w = $urandom_range(12, 1);
                h = $urandom_range(12, 1);
            end
            3:
            begin
                w = $urandom_range(1) ? 256 : $urandom_range(511, 257);
                h = $urandom_range(1);
            end
            4:
            begin
                h = $urandom_range(1) ? 256 : $urandom_range(511, 257);
                w = $urandom_range(1);
            end
            default:
            begin
                w = $urandom_range(1) ? 0 : $urandom_range(8, 1);
                h = (w == 0) ? $urandom_range(8, 1) : 0;
            end
        endcase
        write_reg(CFG_GRID_WIDTH, with_noise(32'(w), GRID_W));
        write_reg(CFG_GRID_HEIGHT, with_noise(32'(h), GRID_W));

        case ($urandom_range(7))
            0:       v = 32'd0;
            1:       v = 32'd1;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'd65536;
            4:       v = 32'd3277;
            default: v = $urandom_range(70000, 1);
        endcase
        write_reg(CFG_CELL_SIZE, with_noise(v, SIZE_W));

        case ($urandom_range(4))
            0:       v = 32'd0;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0000;
            default: v = $urandom;
        endcase
        write_reg(CFG_ORIGIN_X, v);
        v = ($urandom_range(4) == 0) ? 32'h8000_0000 : $urandom;
        write_reg(CFG_ORIGIN_Y, v);

        case ($urandom_range(3))
            0:       v = 32'd0;
            1:       v = 32'd31;
            default: v = $urandom_range(6);
        endcase
        write_reg(CFG_INFLATION, with_noise(v, INFL_W));

        case ($urandom_range(4))
            0:       v = 32'h80;
            1:       v = 32'h7F;
            2:       v = 32'd50;
            default: v = $urandom_range(255);
        endcase
        write_reg(CFG_THRESHOLD, with_noise(v, CELL_W));

        write_reg(CFG_MAP_PRESENT, with_noise(32'($urandom_range(9) != 0), 1));
    endtask

    // Driver: present pending items at the falling edge; hold an item until it is taken.
    always @(negedge clk)
    begin : item_driver
        grid_item_t it;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || took)
        begin
            if (start)
                idle_cnt = draw_gap();
            if (idle_cnt > 0)
            begin
                idle_cnt--;
                start <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                cmd        <= it.cmd;
                pos_x      <= it.px;
                pos_y      <= it.py;
                cell_index <= it.idx;
                cell_value <= it.val;
                start      <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, then log any
    // item taken at this edge. A result always lands at a later edge.
    always @(posedge clk)
    begin : result_monitor
        verdict_t   want;
        grid_item_t seen;
        if (!rst_n)
        begin
            took <= 1'b0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: result with no item pending, collision %0b center_outside %0b",
                             $time, collision, center_outside);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (collision !== want.collision)
                    begin
                        $display("%0t: collision expected %0b actual %0b",
                                 $time, want.collision, collision);
                        mismatches++;
                    end
                    if (center_outside !== want.outside)
                    begin
                        $display("%0t: center_outside expected %0b actual %0b",
                                 $time, want.outside, center_outside);
                        mismatches++;
                    end
                end
            end
            took <= start && !busy;
            if (start && !busy)
            begin
                seen.cmd = cmd;
                seen.px  = pos_x;
                seen.py  = pos_y;
                seen.idx = cell_index;
                seen.val = cell_value;
                expected_verdicts.insert(expected_verdicts.size(), predict_verdict(seen));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n, k, p;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No map after reset: every query is safe. Also hit the store's address extremes.
        queue_query(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_query(32'sd0, 32'sd0);
        queue_write(16'hFFFF, -8'sd128);
        queue_write(16'h0000, 8'sd127);
        wait_idle();

        // Small 4 by 4 map of one-metre cells, a single obstacle in the far corner.
        write_reg(CFG_MAP_PRESENT, 32'd1);
        write_reg(CFG_ORIGIN_X, 32'd0);
        write_reg(CFG_ORIGIN_Y, 32'd0);
        write_reg(CFG_CELL_SIZE, 32'd65536);
        write_reg(CFG_GRID_WIDTH, 32'd4);
        write_reg(CFG_GRID_HEIGHT, 32'd4);
        write_reg(CFG_INFLATION, 32'd1);
        write_reg(CFG_THRESHOLD, 32'd50);
        fill_region(0);
        queue_write(16'd15, 8'sd100);
        queue_query(32'sh8000, 32'sh8000);            // clear window
        queue_query(32'sd131072, 32'sd131072);        // window reaches the obstacle
        queue_query(-32'sh8000, 32'sd0);              // just left of origin, truncates into cell 0
        queue_query(-32'sd65536, 32'sd0);             // one full cell left: off the grid
        queue_query(32'sd262144, 32'sd0);             // just past the right edge
        queue_query(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_write(16'd15, 8'sd50);                  // at the threshold is not an obstacle
        queue_query(32'sd131072, 32'sd131072);
        wait_idle();

        // Zero cell size counts as one unit; zero width puts every centre off the grid.
        write_reg(CFG_CELL_SIZE, 32'd0);
        write_reg(CFG_GRID_WIDTH, 32'd0);
        queue_query(32'sd0, 32'sd0);
        wait_idle();
        // Single cell at the extreme origin, widest window, lowest threshold.
        write_reg(CFG_GRID_WIDTH, 32'd1);
        write_reg(CFG_GRID_HEIGHT, 32'd1);
        write_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
        write_reg(CFG_INFLATION, 32'd31);
        write_reg(CFG_THRESHOLD, 32'h80);
        queue_write(16'd0, draw_cell(1'b0));
        queue_query(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_write(16'd0, 8'sd127);
        queue_query(32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_query(32'sh7FFF_FFFE, 32'sh8000_0000);
        wait_idle();

        // Random phases: new settings, any newly reachable cells loaded, then a burst
        // of items that are mostly aimed queries, with stray queries and writes mixed in.
        while (queued_items < ITEM_TARGET)
        begin
            choose_settings();
            steady_feed = ($urandom_range(3) == 0);
            case ($urandom_range(2))
                0:       density = 0;
                1:       density = 15;
                default: density = 120;
            endcase
            fill_region(density);
            n = $urandom_range(60, 30);
            for (k = 0; k < n; k++)
            begin
                p = $urandom_range(99);
                if (p < 60)
                    queue_aimed_query();
                else if (p < 70)
                    queue_query($urandom, $urandom);
                else if (p < 85 && clamp_dim(cols) * clamp_dim(rows) != 0)
                    queue_write(16'($urandom_range(int'(clamp_dim(cols) * clamp_dim(rows)) - 1)),
                                draw_cell($urandom_range(5) == 0));
                else
                    queue_write(16'($urandom), 8'($urandom));
            end
            wait_idle();
        end

        // Drain, then allow for a stray late result before the verdict.
        repeat (END_PAD) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
